// File: rtl/rwpg_pkg.sv
// ---------------------------------------------------------------------------
// Rainbow wheel pixel generator package
// Shared widths, codes, state types and the divide-by-255 helper.
// ---------------------------------------------------------------------------
package rwpg_pkg;

  localparam int MAX_LEDS_DEF = 1024;

  localparam int OP_W        = 2;
  localparam int IDX_W       = 10;
  localparam int CH_W        = 8;
  localparam int WHEEL_W     = 8;
  localparam int LED_COUNT_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int DVD_W       = IDX_W + WHEEL_W;

  localparam logic [WHEEL_W-1:0]     SEG_EDGE1     = 8'd85;
  localparam logic [WHEEL_W-1:0]     SEG_EDGE2     = 8'd170;
  localparam logic [CH_W-1:0]        CH_MAX        = 8'd255;
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 11'd1;
  localparam logic [CH_W-1:0]        BRIGHT_RST    = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT  = 2'd0,
    CFG_BRIGHTNESS = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_RB = 2'd0,
    SEG_GB = 2'd1,
    SEG_RG = 2'd2
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DIV   = 3'd1,
    S_WHEEL = 3'd2,
    S_MUL_A = 3'd3,
    S_MUL_B = 3'd4,
    S_DONE  = 3'd5
  } state_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] s;
    s = (2*CH_W+1)'(x) + (2*CH_W+1)'(x[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return s[2*CH_W-1:CH_W];
  endfunction

endpackage

// File: rtl/rwpg_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface rwpg_cfg_if;
  import rwpg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/rwpg_in_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Operation code and LED index with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface rwpg_in_if;
  import rwpg_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] led_index;

  modport source (output valid, output operation, output led_index, input ready);
  modport sink   (input valid, input operation, input led_index, output ready);
endinterface

// File: rtl/rwpg_out_if.sv
// ---------------------------------------------------------------------------
// Pixel result channel
// LED index and scaled color channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface rwpg_out_if;
  import rwpg_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input pixel_index, input red, input green, input blue,
                  output ready);
endinterface

// File: rtl/rwpg_div.sv
// ---------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle while busy; done pulses once all DVD_W bits are formed.
// ---------------------------------------------------------------------------
module rwpg_div #(
  parameter int DVD_W = 18,
  parameter int DVS_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

// File: rtl/rainbow_wheel_pixel_generator.sv
// ---------------------------------------------------------------------------
// Rainbow wheel pixel generator
// Maps an LED index and the frame offset through the color wheel and scales
// each channel by the brightness register.
// ---------------------------------------------------------------------------
// A pixel request is accepted only in S_IDLE and runs through S_DIV (the 18-step
// serial divider for index*256/led_count), S_WHEEL, S_MUL_A, S_MUL_B and S_DONE,
// which waits while the last result is still unaccepted; the next request is
// accepted back in S_IDLE. Advance and restart requests produce no result.
// Reset clears the frame offset, sets led_count to 1 and brightness to 255,
// and leaves no result pending.
module rainbow_wheel_pixel_generator #(
  parameter int MAX_LEDS = rwpg_pkg::MAX_LEDS_DEF
) (
  input logic         clk,
  input logic         rst,
  rwpg_cfg_if.sink    cfg,
  rwpg_in_if.sink     request,
  rwpg_out_if.source  pixel
);
  import rwpg_pkg::*;

  localparam int CNT_W = (MAX_LEDS >= 2047) ? LED_COUNT_W : $clog2(MAX_LEDS + 1);

  state_t                 state;
  state_t                 state_next;
  logic [WHEEL_W-1:0]     frame_offset;
  logic [LED_COUNT_W-1:0] led_count;
  logic [CH_W-1:0]        brightness;
  logic [IDX_W-1:0]       idx;
  logic [CNT_W-1:0]       divisor;
  logic                   div_start;
  logic                   div_done;
  logic [DVD_W-1:0]       quotient;
  logic                   req_acc;
  op_t                    req_op;
  logic [WHEEL_W-1:0]     pos;
  logic [WHEEL_W-1:0]     p;
  logic [WHEEL_W-1:0]     pa;
  logic [WHEEL_W+1:0]     pa3;
  seg_t                   seg_now;
  seg_t                   seg;
  logic [CH_W-1:0]        vdn;
  logic [CH_W-1:0]        vup;
  logic [2*CH_W-1:0]      prod;
  logic [CH_W-1:0]        sd;
  logic [CH_W-1:0]        su;
  logic                   out_valid;
  logic                   out_free;
  logic [IDX_W-1:0]       out_index;
  logic [CH_W-1:0]        out_red;
  logic [CH_W-1:0]        out_green;
  logic [CH_W-1:0]        out_blue;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count  <= LED_COUNT_RST;
      brightness <= BRIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_LED_COUNT:  led_count  <= cfg.data;
        CFG_BRIGHTNESS: brightness <= cfg.data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign req_op    = op_t'(request.operation);
  assign req_acc   = request.valid && request.ready;
  assign div_start = req_acc && (req_op == OP_PIXEL);

  always_comb begin
    if (led_count == '0) begin
      divisor = CNT_W'(1);
    end else if (32'(led_count) > 32'(MAX_LEDS)) begin
      divisor = CNT_W'(MAX_LEDS);
    end else begin
      divisor = CNT_W'(led_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset <= '0;
    end else if (req_acc) begin
      unique case (req_op)
        OP_ADVANCE: frame_offset <= frame_offset + WHEEL_W'(1);
        OP_RESTART: frame_offset <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      idx <= request.led_index;
    end
  end

  rwpg_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({request.led_index, WHEEL_W'(0)}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    pos = quotient[WHEEL_W-1:0] + frame_offset;
    p   = ~pos;
    priority if (p < SEG_EDGE1) begin
      seg_now = SEG_RB;
      pa      = p;
    end else if (p < SEG_EDGE2) begin
      seg_now = SEG_GB;
      pa      = p - SEG_EDGE1;
    end else begin
      seg_now = SEG_RG;
      pa      = p - SEG_EDGE2;
    end
    pa3 = (WHEEL_W+2)'(pa) + (WHEEL_W+2)'({pa, 1'b0});
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_WHEEL: begin
        seg <= seg_now;
        vup <= pa3[CH_W-1:0];
        vdn <= CH_MAX - pa3[CH_W-1:0];
      end
      S_MUL_A: begin
        prod <= (2*CH_W)'(vdn) * (2*CH_W)'(brightness);
      end
      S_MUL_B: begin
        sd   <= div255(prod);
        prod <= (2*CH_W)'(vup) * (2*CH_W)'(brightness);
      end
      default: ;
    endcase
  end

  assign su       = div255(prod);
  assign out_free = !out_valid || pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_index <= idx;
      unique case (seg)
        SEG_RB: begin
          out_red   <= sd;
          out_green <= '0;
          out_blue  <= su;
        end
        SEG_GB: begin
          out_red   <= '0;
          out_green <= su;
          out_blue  <= sd;
        end
        SEG_RG: begin
          out_red   <= su;
          out_green <= sd;
          out_blue  <= '0;
        end
        default: begin
          out_red   <= '0;
          out_green <= '0;
          out_blue  <= '0;
        end
      endcase
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.red         = out_red;
  assign pixel.green       = out_green;
  assign pixel.blue        = out_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        request.ready = 1'b1;
        if (request.valid && (req_op == OP_PIXEL)) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WHEEL;
        end
      end
      S_WHEEL: state_next = S_MUL_A;
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  ap_pixel_starts_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("Pixel request did not start the divider.");

  ap_advance_steps: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (req_op == OP_ADVANCE)) |=> (frame_offset == $past(frame_offset) + 8'd1))
    else $error("Frame offset did not advance by one.");

  ap_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("Divider finished outside the divide state.");

  ap_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel.valid) |-> ($past(state) == S_DONE))
    else $error("Result beat appeared without a finished computation.");

  ap_offset_held_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(frame_offset))
    else $error("Frame offset changed while a pixel was in progress.");
`endif

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Rainbow wheel pixel generator testbench
// Drives requests and register writes, predicts each pixel color in a
// scoreboard and checks the results beat by beat under random idling.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwpg_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
  localparam int                   LIMIT_CYCLES = 1_000_000;
  localparam int                   SETTLE       = 40;
  localparam int                   HOLD_CYCLES  = 400;
  localparam int                   PHASE_ITEMS  = 232;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } pixel_t;

  class rainbow_scoreboard;
    logic [LED_COUNT_W-1:0] led_count;
    logic [CH_W-1:0]        brightness;
    logic [WHEEL_W-1:0]     frame_offset;
    pixel_t                 expected_pixels[$];
    int                     errors;

    function new();
      led_count    = LED_COUNT_RST;
      brightness   = BRIGHT_RST;
      frame_offset = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_LED_COUNT: begin
          led_count = data;
        end
        CFG_BRIGHTNESS: begin
          brightness = data[CH_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [CH_W-1:0] dim(logic [CH_W-1:0] v);
      logic [2*CH_W-1:0] prod;
      prod = v * brightness;
      return CH_W'(prod / 16'd255);
    endfunction

    function pixel_t wheel_color(logic [IDX_W-1:0] idx);
      logic [LED_COUNT_W-1:0] divisor;
      logic [DVD_W-1:0]       spread;
      logic [WHEEL_W-1:0]     pos;
      logic [WHEEL_W-1:0]     p;
      pixel_t                 px;
      divisor = led_count;
      if (divisor == 0) divisor = 1;
      if (divisor > MAX_LEDS_DEF) divisor = LED_COUNT_W'(MAX_LEDS_DEF);
      spread = {idx, 8'd0} / divisor;
      pos = WHEEL_W'(spread) + frame_offset;
      p = CH_MAX - pos;
      px.index = idx;
      if (p < SEG_EDGE1) begin
        px.red   = dim(CH_MAX - p * 8'd3);
        px.green = '0;
        px.blue  = dim(p * 8'd3);
      end else if (p < SEG_EDGE2) begin
        p = p - SEG_EDGE1;
        px.red   = '0;
        px.green = dim(p * 8'd3);
        px.blue  = dim(CH_MAX - p * 8'd3);
      end else begin
        p = p - SEG_EDGE2;
        px.red   = dim(p * 8'd3);
        px.green = dim(CH_MAX - p * 8'd3);
        px.blue  = '0;
      end
      return px;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
      case (op)
        OP_PIXEL: begin
          expected_pixels.push_back(wheel_color(idx));
        end
        OP_ADVANCE: begin
          frame_offset = frame_offset + 1'b1;
        end
        OP_RESTART: begin
          frame_offset = '0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel beat: index %0d", got.index);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.index !== want.index) begin
        $error("pixel_index: expected %0d, actual %0d", want.index, got.index);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rwpg_cfg_if cfg_ch ();
  rwpg_in_if  req_ch ();
  rwpg_out_if pix_ch ();

  rainbow_wheel_pixel_generator u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .request (req_ch),
    .pixel   (pix_ch)
  );

  rainbow_scoreboard sb = new();

  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.operation, req_ch.led_index);
      if (pix_ch.valid && pix_ch.ready) begin
        sb.check_pixel({pix_ch.pixel_index, pix_ch.red, pix_ch.green, pix_ch.blue});
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.led_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(logic [LED_COUNT_W-1:0] count, logic [CH_W-1:0] bright);
    write_reg(CFG_LED_COUNT, count);
    write_reg(CFG_BRIGHTNESS, {3'($urandom), bright});
    cfg_ch.valid <= 1'b0;
  endtask

  // Called right after an accepted beat, so the request valid drops here.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 56;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 56;
      end
      default: begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
      end
    endcase
  endtask

  task automatic run_frames(int count, int span);
    int n;
    int roll;
    int burst;
    logic [IDX_W-1:0] idx;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(0, 99);
      idx = IDX_W'($urandom);
      if (roll < 60) begin
        if ($urandom_range(0, 9) < 3) idx = IDX_W'($urandom_range(0, span - 1));
        send_request(OP_PIXEL, idx);
        n++;
      end else if (roll < 88) begin
        send_request(OP_ADVANCE, idx);
        n++;
      end else if (roll < 90) begin
        send_request(OP_RESTART, idx);
        n++;
      end else if (roll < 94) begin
        send_request(OP_UNUSED, idx);
      end else begin
        burst = $urandom_range(8, 48);
        repeat (burst) send_request(OP_ADVANCE, IDX_W'($urandom));
        n += burst;
      end
    end
  endtask

  initial begin
    int ph;
    logic [LED_COUNT_W-1:0] count_sel;
    logic [CH_W-1:0]        bright_sel;
    int                     span;
    rst              <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= '0;
    req_ch.led_index <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting: count 1, full brightness.
    write_reg(CFG_UNUSED, '1);
    cfg_ch.valid <= 1'b0;
    send_request(OP_PIXEL, 10'd0);
    send_request(OP_PIXEL, 10'd1023);
    send_request(OP_PIXEL, 10'd1);
    send_request(OP_ADVANCE, 10'd0);
    send_request(OP_PIXEL, 10'd0);
    send_request(OP_UNUSED, 10'd1023);
    send_request(OP_PIXEL, 10'd0);
    send_request(OP_RESTART, 10'd512);
    send_request(OP_PIXEL, 10'd0);
    wait_idle();

    configure(11'd0, 8'd0);
    send_request(OP_PIXEL, 10'd5);
    send_request(OP_PIXEL, 10'd1023);
    wait_idle();

    configure(11'd2047, 8'd128);
    send_request(OP_PIXEL, 10'd0);
    send_request(OP_PIXEL, 10'd340);
    send_request(OP_PIXEL, 10'd344);
    send_request(OP_PIXEL, 10'd680);
    send_request(OP_PIXEL, 10'd684);
    send_request(OP_PIXEL, 10'd1023);
    wait_idle();

    configure(11'd3, 8'd200);
    send_request(OP_PIXEL, 10'd2);
    send_request(OP_ADVANCE, 10'd0);
    send_request(OP_PIXEL, 10'd1023);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          count_sel = 11'd1024;
          bright_sel = 8'd255;
        end
        1: begin
          count_sel = 11'd0;
          bright_sel = 8'd0;
        end
        2: begin
          count_sel = 11'd2047;
          bright_sel = 8'd1;
        end
        3: begin
          count_sel = 11'd1;
          bright_sel = 8'd254;
        end
        5: begin
          count_sel = LED_COUNT_W'($urandom_range(1025, 2047));
          bright_sel = CH_W'($urandom);
        end
        6: begin
          count_sel = LED_COUNT_W'($urandom_range(1, 16));
          bright_sel = CH_W'($urandom);
        end
        7: begin
          count_sel = LED_COUNT_W'($urandom_range(1, 1024));
          bright_sel = 8'd255;
        end
        default: begin
          count_sel = LED_COUNT_W'($urandom_range(1, 1024));
          bright_sel = CH_W'($urandom);
        end
      endcase
      configure(count_sel, bright_sel);
      set_idling(ph % 4);
      if (ph % 4 == 0 || ph == 6) hold_requests++;
      span = (count_sel == 0) ? 1 : ((count_sel > 1024) ? 1024 : count_sel);
      run_frames(PHASE_ITEMS, span);
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
